/* src/ils_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed list store package
// Shared widths, operation codes and the per-cell control type.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int ACTION_W  = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 7;
    localparam int FIDX_W    = 6;
    localparam int CHUNK     = 8;
    localparam int CHUNK_W   = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_INSERT     = 3'd4,
        ACT_ERASE      = 3'd5,
        ACT_SEARCH     = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MODE_HOLD  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_UP    = 2'd2,
        MODE_DOWN  = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       cmp_en;
    } t_cell_ctrl;

endpackage

/* src/ils_cell.sv */
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one list entry, moves it to or from its neighbors and compares it
// against the searched value.
// ----------------------------------------------------------------------------
module ils_cell #(
    parameter int CNT_W   = 7,
    parameter int CELL_ID = 0
) (
    input  logic                                i_clk,
    input  ils_pkg::t_cell_ctrl                 i_ctrl,
    input  logic [CNT_W-1:0]                    i_index,
    input  logic signed [ils_pkg::VALUE_W-1:0]  i_value,
    input  logic signed [ils_pkg::VALUE_W-1:0]  i_from_low,
    input  logic signed [ils_pkg::VALUE_W-1:0]  i_from_high,
    output logic signed [ils_pkg::VALUE_W-1:0]  o_entry,
    output logic                                o_hit
);
    import ils_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_ID);

    logic signed [VALUE_W-1:0] r_entry;
    logic                      r_hit;
    logic signed [VALUE_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.mode)
            MODE_WRITE: begin
                if (MY_IDX == i_index) n_entry = i_value;
            end
            MODE_UP: begin
                if (MY_IDX == i_index) begin
                    n_entry = i_value;
                end else if (MY_IDX > i_index) begin
                    n_entry = i_from_low;
                end
            end
            MODE_DOWN: begin
                if (MY_IDX >= i_index) n_entry = i_from_high;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctrl.cmp_en) begin
            r_hit <= (MY_IDX < i_index) && (r_entry == i_value);
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

/* src/ils_scan.sv */
// ----------------------------------------------------------------------------
// Indexed list store hit scanner
// Walks the registered hit vector from the top, eight cells per cycle, and
// reports the highest index that hit.
// ----------------------------------------------------------------------------
module ils_scan #(
    parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DEPTH-1:0]           i_hits,
    output logic                       o_done,
    output logic                       o_found,
    output logic [$clog2(DEPTH)-1:0]   o_index
);
    import ils_pkg::*;

    localparam int NCH   = (DEPTH + CHUNK - 1) / CHUNK;
    localparam int PAD_W = NCH * CHUNK;
    localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IDX_W = $clog2(DEPTH);

    logic               r_busy;
    logic [PAD_W-1:0]   r_vec;
    logic [CH_W-1:0]    r_chunk;
    logic [CHUNK-1:0]   top;
    logic [CHUNK_W-1:0] pe;
    logic               any;

    assign top = r_vec[PAD_W-1 -: CHUNK];
    assign any = |top;

    always_comb begin
        pe = '0;
        for (int b = 0; b < CHUNK; b++) begin
            if (top[b]) pe = CHUNK_W'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_vec   <= PAD_W'(i_hits);
            r_chunk <= CH_W'(NCH - 1);
        end else if (r_busy) begin
            if (any || r_chunk == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_vec   <= r_vec << CHUNK;
                r_chunk <= r_chunk - 1'b1;
            end
        end
    end

    assign o_done  = r_busy && (any || r_chunk == '0);
    assign o_found = any;
    assign o_index = IDX_W'({r_chunk, pe});

endmodule

/* src/indexed_list_store_top.sv */
// ----------------------------------------------------------------------------
// Indexed list store
// Ordered list of signed 32-bit values kept in a row of shifting cells, with
// push, pop, insert, erase and last-match search operations.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in      | input     | i_valid / o_stall  | i_action, i_value, i_position
//  out     | output    | o_valid / i_stall  | o_status, o_entry_count,
//          |           |                    | o_free_slots, o_is_empty,
//          |           |                    | o_found, o_found_index
//
// Every operation except search takes effect at the accepting edge. A search
// compares the cells at the accepting edge, then passes through S_LOAD and
// S_SCAN, where the hit scanner examines eight cells per cycle from the top.
// Reset clears the control state and the count; the cells hold no reset value.
// A new transaction is taken once the previous result is in the output
// register; a stalled output holds the next result until it can be loaded.
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
    parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [ils_pkg::ACTION_W-1:0]          i_action,
    input  logic signed [ils_pkg::VALUE_W-1:0]    i_value,
    input  logic [ils_pkg::POS_W-1:0]             i_position,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [ils_pkg::STATUS_W-1:0]          o_status,
    output logic [ils_pkg::CNT_OUT_W-1:0]         o_entry_count,
    output logic [ils_pkg::CNT_OUT_W-1:0]         o_free_slots,
    output logic                                  o_is_empty,
    output logic                                  o_found,
    output logic [ils_pkg::FIDX_W-1:0]            o_found_index
);
    import ils_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_o_valid;
    logic [STATUS_W-1:0]      r_o_status;
    logic [CNT_OUT_W-1:0]     r_o_entry_count;
    logic [CNT_OUT_W-1:0]     r_o_free_slots;
    logic                     r_o_is_empty;
    logic                     r_o_found;
    logic [FIDX_W-1:0]        r_o_found_index;
    t_status                  r_p_status;
    logic                     r_p_found;
    logic [FIDX_W-1:0]        r_p_found_index;

    t_cell_ctrl               ctrl;
    logic [CNT_W-1:0]         cell_index;
    t_status                  n_status;
    t_action                  action;
    logic                     in_accept;
    logic                     out_free;
    logic                     out_load;
    logic                     full;
    logic                     pos_ok;
    logic [DEPTH-1:0]         hits;
    logic signed [VALUE_W-1:0] entry [DEPTH];
    logic                     scan_start;
    logic                     scan_done;
    logic                     scan_found;
    logic [IDX_W-1:0]         scan_index;
    logic [CNT_OUT_W-1:0]     res_count;
    logic [CNT_OUT_W-1:0]     res_free;
    logic                     res_empty;

    assign action    = t_action'(i_action);
    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_o_valid || !i_stall;
    assign full      = (r_count == DEPTH_C);
    assign pos_ok    = CMP_W'(i_position) < CMP_W'(r_count);

    always_comb begin
        n_count    = r_count;
        ctrl       = '{mode: MODE_HOLD, cmp_en: 1'b0};
        cell_index = r_count;
        n_status   = ST_OK;
        if (in_accept) begin
            case (action)
                ACT_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctrl.mode = MODE_WRITE;
                        n_count   = r_count + 1'b1;
                    end
                end
                ACT_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctrl.mode  = MODE_UP;
                        cell_index = '0;
                        n_count    = r_count + 1'b1;
                    end
                end
                ACT_POP_BACK: begin
                    if (r_count != '0) n_count = r_count - 1'b1;
                end
                ACT_POP_FRONT: begin
                    if (r_count != '0) begin
                        ctrl.mode  = MODE_DOWN;
                        cell_index = '0;
                        n_count    = r_count - 1'b1;
                    end
                end
                ACT_INSERT: begin
                    if (!pos_ok) begin
                        n_status = ST_RANGE;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctrl.mode  = MODE_UP;
                        cell_index = CNT_W'(i_position);
                        n_count    = r_count + 1'b1;
                    end
                end
                ACT_ERASE: begin
                    if (!pos_ok) begin
                        n_status = ST_RANGE;
                    end else begin
                        ctrl.mode  = MODE_DOWN;
                        cell_index = CNT_W'(i_position);
                        n_count    = r_count - 1'b1;
                    end
                end
                ACT_SEARCH: begin
                    ctrl.cmp_en = 1'b1;
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_W-1:0] from_low;
        logic signed [VALUE_W-1:0] from_high;
        if (g == 0) begin : g_first
            assign from_low = '0;
        end else begin : g_mid
            assign from_low = entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign from_high = '0;
        end else begin : g_inner
            assign from_high = entry[g+1];
        end
        ils_cell #(
            .CNT_W   (CNT_W),
            .CELL_ID (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_index     (cell_index),
            .i_value     (i_value),
            .i_from_low  (from_low),
            .i_from_high (from_high),
            .o_entry     (entry[g]),
            .o_hit       (hits[g])
        );
    end

    assign scan_start = (r_state == S_LOAD);

    ils_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_hits  (hits),
        .o_done  (scan_done),
        .o_found (scan_found),
        .o_index (scan_index)
    );

    assign res_count = CNT_OUT_W'(n_count);
    assign res_free  = CNT_OUT_W'(DEPTH_C - n_count);
    assign res_empty = (n_count == '0);

    assign out_load = out_free
                      && (((r_state == S_IDLE) && in_accept && (action != ACT_SEARCH))
                          || ((r_state == S_SCAN) && scan_done)
                          || (r_state == S_HOLD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (action == ACT_SEARCH) begin
                            r_state <= S_LOAD;
                        end else if (out_free) begin
                            r_o_status      <= n_status;
                            r_o_found       <= 1'b0;
                            r_o_found_index <= '0;
                            r_o_entry_count <= res_count;
                            r_o_free_slots  <= res_free;
                            r_o_is_empty    <= res_empty;
                        end else begin
                            r_p_status      <= n_status;
                            r_p_found       <= 1'b0;
                            r_p_found_index <= '0;
                            r_state         <= S_HOLD;
                        end
                    end
                end
                S_LOAD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_done) begin
                        if (out_free) begin
                            r_o_status      <= ST_OK;
                            r_o_found       <= scan_found;
                            r_o_found_index <= scan_found ? FIDX_W'(scan_index) : '0;
                            r_o_entry_count <= res_count;
                            r_o_free_slots  <= res_free;
                            r_o_is_empty    <= res_empty;
                            r_state         <= S_IDLE;
                        end else begin
                            r_p_status      <= ST_OK;
                            r_p_found       <= scan_found;
                            r_p_found_index <= scan_found ? FIDX_W'(scan_index) : '0;
                            r_state         <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_o_status      <= r_p_status;
                        r_o_found       <= r_p_found;
                        r_o_found_index <= r_p_found_index;
                        r_o_entry_count <= res_count;
                        r_o_free_slots  <= res_free;
                        r_o_is_empty    <= res_empty;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_entry_count = r_o_entry_count;
    assign o_free_slots  = r_o_free_slots;
    assign o_is_empty    = r_o_is_empty;
    assign o_found       = r_o_found;
    assign o_found_index = r_o_found_index;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("Entry count exceeds list depth.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1)
                 || (r_count == $past(r_count) - 1'b1))
        else $error("Entry count changed by more than one.");

    a_direct_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && action != ACT_SEARCH && out_free) |=> o_valid)
        else $error("Result of a single-cycle transaction was not presented.");

    a_scan_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> (r_state == S_SCAN))
        else $error("Scanner finished outside of the search state.");

endmodule
